// File: hdl/bsp_loc_pkg.sv
// Shared types and constants for the BSP point leaf locator.
package bsp_loc_pkg;

    // Field widths fixed by the item format
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 13;
    localparam int CHILD_W  = 14;
    localparam int NORMAL_W = 16;
    localparam int COORD_W  = 24;
    localparam int LEAF_W   = 13;
    localparam int STEPS_W  = 7;

    // Dot product arithmetic: Q15.8 * Q1.14 gives Q.22 terms
    localparam int PROD_W     = COORD_W + NORMAL_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int DIST_SHIFT = 14;

    // Largest value the step count output can show
    localparam int STEPS_SAT = 127;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_NODE  = 2'd0,
        CMD_WRITE_PLANE = 2'd1,
        CMD_LOCATE      = 2'd2,
        CMD_UNUSED      = 2'd3
    } cmd_t;

    // Which product the shared multiplier forms this cycle
    typedef enum logic [1:0] {
        TERM_X     = 2'd0,
        TERM_Y     = 2'd1,
        TERM_Z     = 2'd2,
        TERM_FLUSH = 2'd3
    } term_t;

    typedef struct packed {
        logic               en;
        term_t              term;
    } dot_ctrl_t;

    typedef struct packed {
        logic [INDEX_W-1:0]        plane_ref;
        logic signed [CHILD_W-1:0] back_child;
        logic signed [CHILD_W-1:0] front_child;
    } node_entry_t;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] normal_z;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [COORD_W-1:0]  distance;
    } plane_entry_t;

endpackage

// File: hdl/bsp_point_leaf_locator.sv
// Top level of the BSP point leaf locator: command decode and walk sequencer.
//
// Write commands (node or plane) return no item. A locate command walks
// the tree from node 0, one level per step, for at most MAX_STEPS steps.
// Each step is a plane table read, a pass through the one shared
// multiply-accumulate unit (three products and a final add, with the
// distance compare folded into the sum) and a decide state that also
// issues the next node read. The input side stalls from an accepted
// locate until its result is loaded into the output register. A result
// that cannot leave the output register holds the walker in its last
// step. The tables have no reset and need no clearing pass; the user
// must write entries before use, and the block itself does not enforce it.
module bsp_point_leaf_locator #(
    parameter int NODE_COUNT  = 4096,
    parameter int PLANE_COUNT = 8192,
    parameter int LEAF_COUNT  = 8192,
    parameter int MAX_STEPS   = 64
) (
    input  logic                                       clk,
    input  logic                                       rst_n,

    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic [bsp_loc_pkg::CMD_W-1:0]              command,
    input  logic [bsp_loc_pkg::INDEX_W-1:0]            entry_index,
    input  logic [bsp_loc_pkg::INDEX_W-1:0]            plane_ref,
    input  logic signed [bsp_loc_pkg::CHILD_W-1:0]     front_child,
    input  logic signed [bsp_loc_pkg::CHILD_W-1:0]     back_child,
    input  logic signed [bsp_loc_pkg::NORMAL_W-1:0]    normal_x,
    input  logic signed [bsp_loc_pkg::NORMAL_W-1:0]    normal_y,
    input  logic signed [bsp_loc_pkg::NORMAL_W-1:0]    normal_z,
    input  logic signed [bsp_loc_pkg::COORD_W-1:0]     plane_distance,
    input  logic signed [bsp_loc_pkg::COORD_W-1:0]     point_x,
    input  logic signed [bsp_loc_pkg::COORD_W-1:0]     point_y,
    input  logic signed [bsp_loc_pkg::COORD_W-1:0]     point_z,

    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic [bsp_loc_pkg::LEAF_W-1:0]             leaf_index,
    output logic                                       status,
    output logic [bsp_loc_pkg::STEPS_W-1:0]            steps_taken
);

    localparam int STEP_W     = $clog2(MAX_STEPS + 1);
    localparam int STEP_EXT_W = (STEP_W > bsp_loc_pkg::STEPS_W) ? STEP_W
                                                                : bsp_loc_pkg::STEPS_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PLANE  = 4'b0010,
        S_MUL    = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    bsp_loc_pkg::term_t term_reg;
    bsp_loc_pkg::term_t term_next;

    logic [STEP_W-1:0] steps_reg;
    logic [STEP_W-1:0] steps_next;
    logic [STEP_W-1:0] steps_inc;

    logic signed [bsp_loc_pkg::COORD_W-1:0] px_reg;
    logic signed [bsp_loc_pkg::COORD_W-1:0] py_reg;
    logic signed [bsp_loc_pkg::COORD_W-1:0] pz_reg;

    logic                                out_valid_reg;
    logic [bsp_loc_pkg::LEAF_W-1:0]      leaf_reg;
    logic                                status_reg;
    logic [bsp_loc_pkg::STEPS_W-1:0]     steps_out_reg;

    logic in_accept;
    logic locate_accept;
    logic out_free;
    logic out_load;

    bsp_loc_pkg::node_entry_t  node_wr;
    bsp_loc_pkg::node_entry_t  node_rd;
    bsp_loc_pkg::plane_entry_t plane_wr;
    bsp_loc_pkg::plane_entry_t plane_rd;
    bsp_loc_pkg::dot_ctrl_t    dot_ctrl;

    logic                                   node_rd_en;
    logic [bsp_loc_pkg::INDEX_W-1:0]        node_rd_index;
    logic                                   plane_rd_en;
    logic                                   behind;

    logic signed [bsp_loc_pkg::CHILD_W-1:0] child;
    logic                                   child_is_leaf;
    logic                                   walk_done;
    logic [bsp_loc_pkg::LEAF_W-1:0]         leaf_raw;
    logic [bsp_loc_pkg::LEAF_W-1:0]         leaf_clamped;
    logic [STEP_EXT_W-1:0]                  steps_ext;
    logic [bsp_loc_pkg::STEPS_W-1:0]        steps_sat;

    // Handshake decode
    assign in_stall      = (state_reg != S_IDLE);
    assign in_accept     = in_valid && !in_stall;
    assign locate_accept = in_accept && (command == bsp_loc_pkg::CMD_LOCATE);
    assign out_free      = !out_valid_reg || !out_stall;

    // Pack the write payloads
    assign node_wr.plane_ref   = plane_ref;
    assign node_wr.front_child = front_child;
    assign node_wr.back_child  = back_child;
    assign plane_wr.normal_x   = normal_x;
    assign plane_wr.normal_y   = normal_y;
    assign plane_wr.normal_z   = normal_z;
    assign plane_wr.distance   = plane_distance;

    // Choose the child and classify the end of the walk
    assign child         = behind ? node_rd.back_child : node_rd.front_child;
    assign child_is_leaf = child[bsp_loc_pkg::CHILD_W-1];
    assign steps_inc     = steps_reg + STEP_W'(1);
    assign walk_done     = child_is_leaf || (steps_inc == STEP_W'(MAX_STEPS));

    // Leaf number is -(child+1), clamped to the last leaf
    assign leaf_raw     = ~child[bsp_loc_pkg::LEAF_W-1:0];
    assign leaf_clamped = (32'(leaf_raw) >= LEAF_COUNT) ? bsp_loc_pkg::LEAF_W'(LEAF_COUNT - 1)
                                                        : leaf_raw;

    // Saturate the visit count for the output field
    assign steps_ext = STEP_EXT_W'(steps_inc);
    assign steps_sat = (steps_ext > STEP_EXT_W'(bsp_loc_pkg::STEPS_SAT))
                     ? bsp_loc_pkg::STEPS_W'(bsp_loc_pkg::STEPS_SAT)
                     : steps_ext[bsp_loc_pkg::STEPS_W-1:0];

    // Walk sequencer
    always_comb
    begin
        state_next    = state_reg;
        term_next     = term_reg;
        steps_next    = steps_reg;
        node_rd_en    = 1'b0;
        node_rd_index = '0;
        plane_rd_en   = 1'b0;
        dot_ctrl.en   = 1'b0;
        dot_ctrl.term = term_reg;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (locate_accept)
                begin
                    node_rd_en = 1'b1;
                    steps_next = '0;
                    state_next = S_PLANE;
                end
            end
            S_PLANE:
            begin
                plane_rd_en = 1'b1;
                term_next   = bsp_loc_pkg::TERM_X;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                dot_ctrl.en = 1'b1;
                term_next   = bsp_loc_pkg::term_t'(term_reg + 2'd1);
                if (term_reg == bsp_loc_pkg::TERM_FLUSH)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (walk_done)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    node_rd_en    = 1'b1;
                    node_rd_index = child[bsp_loc_pkg::INDEX_W-1:0];
                    steps_next    = steps_inc;
                    state_next    = S_PLANE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            term_reg      <= bsp_loc_pkg::TERM_X;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            steps_reg <= steps_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latch the query point and the result payload
    always_ff @(posedge clk)
    begin
        if (locate_accept)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
            pz_reg <= point_z;
        end
        if (out_load)
        begin
            leaf_reg      <= child_is_leaf ? leaf_clamped : '0;
            status_reg    <= !child_is_leaf;
            steps_out_reg <= steps_sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign leaf_index  = leaf_reg;
    assign status      = status_reg;
    assign steps_taken = steps_out_reg;

    bsp_loc_node_store #(
        .NODE_COUNT (NODE_COUNT)
    ) u_node_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_accept && (command == bsp_loc_pkg::CMD_WRITE_NODE)),
        .wr_index (entry_index),
        .wr_entry (node_wr),
        .rd_en    (node_rd_en),
        .rd_index (node_rd_index),
        .rd_entry (node_rd)
    );

    bsp_loc_plane_store #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_plane_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_accept && (command == bsp_loc_pkg::CMD_WRITE_PLANE)),
        .wr_index (entry_index),
        .wr_entry (plane_wr),
        .rd_en    (plane_rd_en),
        .rd_index (node_rd.plane_ref),
        .rd_entry (plane_rd)
    );

    bsp_loc_dot_unit u_dot_unit (
        .clk     (clk),
        .ctrl    (dot_ctrl),
        .point_x (px_reg),
        .point_y (py_reg),
        .point_z (pz_reg),
        .plane   (plane_rd),
        .behind  (behind)
    );

    // Step count stays below the limit while a walk runs
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (32'(steps_reg) < MAX_STEPS))
        else $error("step counter reached the limit inside a walk");

    // The decide step follows only the multiply phase or a held result
    a_decide_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |->
            (($past(state_reg) == S_MUL) || ($past(state_reg) == S_DECIDE)))
        else $error("decide step entered without a finished dot product");

    // The multiply phase runs all four terms without a break
    a_mul_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && term_reg != bsp_loc_pkg::TERM_FLUSH) |=>
            (state_reg == S_MUL))
        else $error("multiply phase cut short");

    // A result for an unfinished walk carries leaf zero
    a_limit_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (leaf_reg == '0))
        else $error("step limit result with nonzero leaf");

endmodule

// File: hdl/bsp_loc_node_store.sv
// Node table memory: plane reference and both children for each node.
module bsp_loc_node_store #(
    parameter int NODE_COUNT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [bsp_loc_pkg::INDEX_W-1:0]   wr_index,
    input  bsp_loc_pkg::node_entry_t          wr_entry,
    input  logic                              rd_en,
    input  logic [bsp_loc_pkg::INDEX_W-1:0]   rd_index,
    output bsp_loc_pkg::node_entry_t          rd_entry
);

    localparam int AW     = $clog2(NODE_COUNT);
    localparam int AW_EXT = (AW > bsp_loc_pkg::INDEX_W) ? AW : bsp_loc_pkg::INDEX_W;

    bsp_loc_pkg::node_entry_t mem [NODE_COUNT];
    bsp_loc_pkg::node_entry_t mem_q_reg;
    logic                     in_range_reg;

    logic [AW_EXT-1:0] wr_ext;
    logic [AW_EXT-1:0] rd_ext;
    logic              wr_in_range;
    logic              rd_in_range;

    // Map the fixed-width indexes onto the table address
    assign wr_ext      = AW_EXT'(wr_index);
    assign rd_ext      = AW_EXT'(rd_index);
    assign wr_in_range = (32'(wr_index) < NODE_COUNT);
    assign rd_in_range = (32'(rd_index) < NODE_COUNT);

    // Write and read the table
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_ext[AW-1:0]] <= wr_entry;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_ext[AW-1:0]];
        end
    end

    // Hold the range flag of the last read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_range_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            in_range_reg <= rd_in_range;
        end
    end

    // A node beyond the table reads as all zero
    assign rd_entry = in_range_reg ? mem_q_reg : '0;

endmodule

// File: hdl/bsp_loc_plane_store.sv
// Plane table memory: normal and distance for each plane.
module bsp_loc_plane_store #(
    parameter int PLANE_COUNT = 8192
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [bsp_loc_pkg::INDEX_W-1:0]   wr_index,
    input  bsp_loc_pkg::plane_entry_t         wr_entry,
    input  logic                              rd_en,
    input  logic [bsp_loc_pkg::INDEX_W-1:0]   rd_index,
    output bsp_loc_pkg::plane_entry_t         rd_entry
);

    localparam int AW     = $clog2(PLANE_COUNT);
    localparam int AW_EXT = (AW > bsp_loc_pkg::INDEX_W) ? AW : bsp_loc_pkg::INDEX_W;

    bsp_loc_pkg::plane_entry_t mem [PLANE_COUNT];
    bsp_loc_pkg::plane_entry_t mem_q_reg;
    logic                      in_range_reg;

    logic [AW_EXT-1:0] wr_ext;
    logic [AW_EXT-1:0] rd_ext;
    logic              wr_in_range;
    logic              rd_in_range;

    // Map the fixed-width indexes onto the table address
    assign wr_ext      = AW_EXT'(wr_index);
    assign rd_ext      = AW_EXT'(rd_index);
    assign wr_in_range = (32'(wr_index) < PLANE_COUNT);
    assign rd_in_range = (32'(rd_index) < PLANE_COUNT);

    // Write and read the table
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_ext[AW-1:0]] <= wr_entry;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_ext[AW-1:0]];
        end
    end

    // Hold the range flag of the last read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_range_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            in_range_reg <= rd_in_range;
        end
    end

    // A plane beyond the table reads as all zero, so the point lies in front
    assign rd_entry = in_range_reg ? mem_q_reg : '0;

endmodule

// File: hdl/bsp_loc_dot_unit.sv
// Shared multiply-accumulate unit: forms dot(point, normal) - distance.
module bsp_loc_dot_unit (
    input  logic                                     clk,
    input  bsp_loc_pkg::dot_ctrl_t                   ctrl,
    input  logic signed [bsp_loc_pkg::COORD_W-1:0]   point_x,
    input  logic signed [bsp_loc_pkg::COORD_W-1:0]   point_y,
    input  logic signed [bsp_loc_pkg::COORD_W-1:0]   point_z,
    input  bsp_loc_pkg::plane_entry_t                plane,
    output logic                                     behind
);

    logic signed [bsp_loc_pkg::COORD_W-1:0]  p_sel;
    logic signed [bsp_loc_pkg::NORMAL_W-1:0] n_sel;
    logic signed [bsp_loc_pkg::PROD_W-1:0]   prod_next;
    logic signed [bsp_loc_pkg::PROD_W-1:0]   prod_reg;
    logic signed [bsp_loc_pkg::ACC_W-1:0]    acc_reg;
    logic signed [bsp_loc_pkg::ACC_W-1:0]    acc_next;
    logic signed [bsp_loc_pkg::ACC_W-1:0]    dist_scaled;

    // Pick the operand pair for the multiplier
    always_comb
    begin
        unique case (ctrl.term)
            bsp_loc_pkg::TERM_X:
            begin
                p_sel = point_x;
                n_sel = plane.normal_x;
            end
            bsp_loc_pkg::TERM_Y:
            begin
                p_sel = point_y;
                n_sel = plane.normal_y;
            end
            bsp_loc_pkg::TERM_Z:
            begin
                p_sel = point_z;
                n_sel = plane.normal_z;
            end
            default:
            begin
                p_sel = '0;
                n_sel = '0;
            end
        endcase
    end

    assign prod_next   = p_sel * n_sel;
    assign dist_scaled = bsp_loc_pkg::ACC_W'(plane.distance) <<< bsp_loc_pkg::DIST_SHIFT;

    // Start from minus the distance, then add each product in the cycle after it is formed
    always_comb
    begin
        if (ctrl.term == bsp_loc_pkg::TERM_X)
        begin
            acc_next = -dist_scaled;
        end
        else
        begin
            acc_next = acc_reg + bsp_loc_pkg::ACC_W'(prod_reg);
        end
    end

    // Advance the product and accumulator registers
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    // Negative difference means the point is behind the plane
    assign behind = acc_reg[bsp_loc_pkg::ACC_W-1];

endmodule

// File: tb/bsp_point_leaf_locator_tb.sv
// Self-checking testbench for the BSP point leaf locator: table loads and tree walks.
`timescale 1ns / 1ps

module bsp_point_leaf_locator_tb;

    localparam int NODE_COUNT   = 4096;
    localparam int PLANE_COUNT  = 8192;
    localparam int LEAF_COUNT   = 8192;
    localparam int MAX_STEPS    = 64;
    localparam int ITEM_GOAL    = 1750;
    localparam int CALM_ITEMS   = 150;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 1 + 6 * MAX_STEPS + 16;

    // Walk status codes on the status output
    localparam logic WALK_FOUND = 1'b0;
    localparam logic WALK_LIMIT = 1'b1;

    typedef struct {
        bsp_loc_pkg::cmd_t                       cmd;
        logic [bsp_loc_pkg::INDEX_W-1:0]         entry_index;
        logic [bsp_loc_pkg::INDEX_W-1:0]         plane_ref;
        logic signed [bsp_loc_pkg::CHILD_W-1:0]  front_child;
        logic signed [bsp_loc_pkg::CHILD_W-1:0]  back_child;
        logic signed [bsp_loc_pkg::NORMAL_W-1:0] normal_x;
        logic signed [bsp_loc_pkg::NORMAL_W-1:0] normal_y;
        logic signed [bsp_loc_pkg::NORMAL_W-1:0] normal_z;
        logic signed [bsp_loc_pkg::COORD_W-1:0]  plane_distance;
        logic signed [bsp_loc_pkg::COORD_W-1:0]  point_x;
        logic signed [bsp_loc_pkg::COORD_W-1:0]  point_y;
        logic signed [bsp_loc_pkg::COORD_W-1:0]  point_z;
    } tree_item_t;

    typedef struct {
        logic [bsp_loc_pkg::LEAF_W-1:0]  leaf;
        logic                            status;
        logic [bsp_loc_pkg::STEPS_W-1:0] steps;
    } leaf_result_t;

    // Shadow tree tables and the queue of leaf lookups still to come out
    class leaf_scoreboard;
        bsp_loc_pkg::node_entry_t  node_tbl[NODE_COUNT];
        bsp_loc_pkg::plane_entry_t plane_tbl[PLANE_COUNT];
        leaf_result_t              expected_q[$];
        int unsigned               fail_count;

        function new();
            foreach (node_tbl[i]) node_tbl[i] = '0;
            foreach (plane_tbl[i]) plane_tbl[i] = '0;
            fail_count = 0;
        endfunction

        function void report(string msg);
            fail_count++;
            if (fail_count <= 10)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Walk from node 0 until a leaf or the step cap
        function leaf_result_t walk_tree(logic signed [bsp_loc_pkg::COORD_W-1:0] px,
                                         logic signed [bsp_loc_pkg::COORD_W-1:0] py,
                                         logic signed [bsp_loc_pkg::COORD_W-1:0] pz);
            leaf_result_t              res;
            bsp_loc_pkg::node_entry_t  nd;
            bsp_loc_pkg::plane_entry_t pl;
            longint                    dot, lhs, next, node, leaf;
            int unsigned               visits;
            bit                        reached;
            node    = 0;
            leaf    = 0;
            visits  = 0;
            reached = 1'b0;
            while (visits < MAX_STEPS && !reached)
            begin
                nd = (node < NODE_COUNT) ? node_tbl[node] : '0;
                pl = (nd.plane_ref < PLANE_COUNT) ? plane_tbl[nd.plane_ref] : '0;
                visits++;
                dot = longint'(px) * longint'($signed(pl.normal_x))
                    + longint'(py) * longint'($signed(pl.normal_y))
                    + longint'(pz) * longint'($signed(pl.normal_z));
                lhs = longint'($signed(pl.distance)) <<< bsp_loc_pkg::DIST_SHIFT;
                next = (dot < lhs) ? longint'($signed(nd.back_child))
                                   : longint'($signed(nd.front_child));
                if (next < 0)
                begin
                    reached = 1'b1;
                    leaf = -(next + 1);
                    if (leaf >= LEAF_COUNT)
                        leaf = longint'(LEAF_COUNT - 1);
                end
                else
                begin
                    node = next;
                end
            end
            res.leaf   = reached ? bsp_loc_pkg::LEAF_W'(leaf) : '0;
            res.status = reached ? WALK_FOUND : WALK_LIMIT;
            res.steps  = (visits > bsp_loc_pkg::STEPS_SAT)
                       ? bsp_loc_pkg::STEPS_W'(bsp_loc_pkg::STEPS_SAT)
                       : bsp_loc_pkg::STEPS_W'(visits);
            return res;
        endfunction

        // Apply a load or queue the leaf a locate must return
        function void note_item(tree_item_t it);
            case (it.cmd)
                bsp_loc_pkg::CMD_WRITE_NODE:
                    if (it.entry_index < NODE_COUNT)
                    begin
                        node_tbl[it.entry_index].plane_ref   = it.plane_ref;
                        node_tbl[it.entry_index].front_child = it.front_child;
                        node_tbl[it.entry_index].back_child  = it.back_child;
                    end
                bsp_loc_pkg::CMD_WRITE_PLANE:
                    if (it.entry_index < PLANE_COUNT)
                    begin
                        plane_tbl[it.entry_index].normal_x = it.normal_x;
                        plane_tbl[it.entry_index].normal_y = it.normal_y;
                        plane_tbl[it.entry_index].normal_z = it.normal_z;
                        plane_tbl[it.entry_index].distance = it.plane_distance;
                    end
                bsp_loc_pkg::CMD_LOCATE:
                    expected_q.push_back(walk_tree(it.point_x, it.point_y, it.point_z));
                default:
                    ;
            endcase
        endfunction

        // Compare a delivered item against the oldest expected leaf
        function void check_result(leaf_result_t got);
            leaf_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with none pending: leaf %0d status %0d steps %0d",
                                 got.leaf, got.status, got.steps));
                return;
            end
            want = expected_q.pop_front();
            if (got.leaf !== want.leaf)
                report($sformatf("leaf_index expected %0d, got %0d", want.leaf, got.leaf));
            if (got.status !== want.status)
                report($sformatf("status expected %0d, got %0d", want.status, got.status));
            if (got.steps !== want.steps)
                report($sformatf("steps_taken expected %0d, got %0d", want.steps, got.steps));
        endfunction
    endclass

    logic                                    clk;
    logic                                    rst_n;
    logic                                    in_valid;
    logic                                    in_stall;
    logic [bsp_loc_pkg::CMD_W-1:0]           command;
    logic [bsp_loc_pkg::INDEX_W-1:0]         entry_index;
    logic [bsp_loc_pkg::INDEX_W-1:0]         plane_ref;
    logic signed [bsp_loc_pkg::CHILD_W-1:0]  front_child;
    logic signed [bsp_loc_pkg::CHILD_W-1:0]  back_child;
    logic signed [bsp_loc_pkg::NORMAL_W-1:0] normal_x;
    logic signed [bsp_loc_pkg::NORMAL_W-1:0] normal_y;
    logic signed [bsp_loc_pkg::NORMAL_W-1:0] normal_z;
    logic signed [bsp_loc_pkg::COORD_W-1:0]  plane_distance;
    logic signed [bsp_loc_pkg::COORD_W-1:0]  point_x;
    logic signed [bsp_loc_pkg::COORD_W-1:0]  point_y;
    logic signed [bsp_loc_pkg::COORD_W-1:0]  point_z;
    logic                                    out_valid;
    logic                                    out_stall;
    logic [bsp_loc_pkg::LEAF_W-1:0]          leaf_index;
    logic                                    status;
    logic [bsp_loc_pkg::STEPS_W-1:0]         steps_taken;

    leaf_scoreboard                  board;
    bit                              idle_on = 1'b1;
    bit                              long_hold_req = 1'b0;
    int unsigned                     work_sent = 0;
    bit                              node_live[NODE_COUNT];
    bit                              plane_live[PLANE_COUNT];
    logic [bsp_loc_pkg::INDEX_W-1:0] live_nodes[$];
    logic [bsp_loc_pkg::INDEX_W-1:0] live_planes[$];

    bsp_point_leaf_locator #(
        .NODE_COUNT  (NODE_COUNT),
        .PLANE_COUNT (PLANE_COUNT),
        .LEAF_COUNT  (LEAF_COUNT),
        .MAX_STEPS   (MAX_STEPS)
    ) dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Give up on a hung run
    initial
    begin
        #20_000_000;
        $display("bsp_point_leaf_locator regression: fail");
        $finish;
    end

    // Stall the result side in short random bursts, or once for a long stretch
    initial
    begin
        int unsigned burst;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watch both handshakes and feed the scoreboard
    always @(posedge clk)
    begin : watch
        tree_item_t   seen;
        leaf_result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seen.cmd            = bsp_loc_pkg::cmd_t'(command);
                seen.entry_index    = entry_index;
                seen.plane_ref      = plane_ref;
                seen.front_child    = front_child;
                seen.back_child     = back_child;
                seen.normal_x       = normal_x;
                seen.normal_y       = normal_y;
                seen.normal_z       = normal_z;
                seen.plane_distance = plane_distance;
                seen.point_x        = point_x;
                seen.point_y        = point_y;
                seen.point_z        = point_z;
                board.note_item(seen);
            end
            if (out_valid && !out_stall)
            begin
                got.leaf   = leaf_index;
                got.status = status;
                got.steps  = steps_taken;
                board.check_result(got);
            end
        end
    end

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0:       return int'($urandom_range(0, 16777215)) - 8388608;
            1:       return int'($urandom_range(0, 8192)) - 4096;
            2:       return ($urandom_range(0, 1) != 0) ? 8388607 : -8388608;
            default: return int'($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    function automatic int rand_normal();
        case ($urandom_range(0, 3))
            0:       return ($urandom_range(0, 1) != 0) ? 16384 : -16384;
            1:       return 0;
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    function automatic int rand_distance();
        case ($urandom_range(0, 2))
            0:       return int'($urandom_range(0, 16777215)) - 8388608;
            1:       return int'($urandom_range(0, 131072)) - 65536;
            default: return ($urandom_range(0, 1) != 0) ? 8388607 : -8388608;
        endcase
    endfunction

    function automatic int rand_leaf();
        return -int'($urandom_range(1, LEAF_COUNT));
    endfunction

    // Fill every field with in-range noise; callers set the ones that matter
    function automatic tree_item_t blank_item(input bsp_loc_pkg::cmd_t c);
        tree_item_t it;
        it.cmd            = c;
        it.entry_index    = bsp_loc_pkg::INDEX_W'($urandom_range(0, 8191));
        it.plane_ref      = bsp_loc_pkg::INDEX_W'($urandom_range(0, 8191));
        it.front_child    = bsp_loc_pkg::CHILD_W'(int'($urandom_range(0, 12287)) - 8192);
        it.back_child     = bsp_loc_pkg::CHILD_W'(int'($urandom_range(0, 12287)) - 8192);
        it.normal_x       = bsp_loc_pkg::NORMAL_W'(rand_normal());
        it.normal_y       = bsp_loc_pkg::NORMAL_W'(rand_normal());
        it.normal_z       = bsp_loc_pkg::NORMAL_W'(rand_normal());
        it.plane_distance = bsp_loc_pkg::COORD_W'(rand_distance());
        it.point_x        = bsp_loc_pkg::COORD_W'(rand_coord());
        it.point_y        = bsp_loc_pkg::COORD_W'(rand_coord());
        it.point_z        = bsp_loc_pkg::COORD_W'(rand_coord());
        return it;
    endfunction

    // Pick a child that is a leaf or a node loaded before any locate follows
    function automatic int pick_child(input logic [bsp_loc_pkg::INDEX_W-1:0] ids[$],
                                      input int k);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45 || (r < 85 && k + 1 >= ids.size()))
            return rand_leaf();
        if (r < 85)
            return int'(ids[$urandom_range(k + 1, ids.size() - 1)]);
        if (r < 95)
            return int'(live_nodes[$urandom_range(0, live_nodes.size() - 1)]);
        return int'(ids[$urandom_range(0, k)]);
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_item(input tree_item_t it);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= it.cmd;
        entry_index    <= it.entry_index;
        plane_ref      <= it.plane_ref;
        front_child    <= it.front_child;
        back_child     <= it.back_child;
        normal_x       <= it.normal_x;
        normal_y       <= it.normal_y;
        normal_z       <= it.normal_z;
        plane_distance <= it.plane_distance;
        point_x        <= it.point_x;
        point_y        <= it.point_y;
        point_z        <= it.point_z;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (it.cmd != bsp_loc_pkg::CMD_UNUSED &&
            !(it.cmd == bsp_loc_pkg::CMD_WRITE_NODE && it.entry_index >= NODE_COUNT))
            work_sent++;
    endtask

    task automatic send_node(input int idx, input int pref, input int front, input int back);
        tree_item_t it;
        it             = blank_item(bsp_loc_pkg::CMD_WRITE_NODE);
        it.entry_index = bsp_loc_pkg::INDEX_W'(idx);
        it.plane_ref   = bsp_loc_pkg::INDEX_W'(pref);
        it.front_child = bsp_loc_pkg::CHILD_W'(front);
        it.back_child  = bsp_loc_pkg::CHILD_W'(back);
        if (idx < NODE_COUNT && !node_live[idx])
        begin
            node_live[idx] = 1'b1;
            live_nodes.push_back(bsp_loc_pkg::INDEX_W'(idx));
        end
        send_item(it);
    endtask

    task automatic send_plane(input int idx, input int nx, input int ny, input int nz,
                              input int plane_dist);
        tree_item_t it;
        it                = blank_item(bsp_loc_pkg::CMD_WRITE_PLANE);
        it.entry_index    = bsp_loc_pkg::INDEX_W'(idx);
        it.normal_x       = bsp_loc_pkg::NORMAL_W'(nx);
        it.normal_y       = bsp_loc_pkg::NORMAL_W'(ny);
        it.normal_z       = bsp_loc_pkg::NORMAL_W'(nz);
        it.plane_distance = bsp_loc_pkg::COORD_W'(plane_dist);
        if (idx < PLANE_COUNT && !plane_live[idx])
        begin
            plane_live[idx] = 1'b1;
            live_planes.push_back(bsp_loc_pkg::INDEX_W'(idx));
        end
        send_item(it);
    endtask

    task automatic send_locate(input int x, input int y, input int z);
        tree_item_t it;
        it         = blank_item(bsp_loc_pkg::CMD_LOCATE);
        it.point_x = bsp_loc_pkg::COORD_W'(x);
        it.point_y = bsp_loc_pkg::COORD_W'(y);
        it.point_z = bsp_loc_pkg::COORD_W'(z);
        send_item(it);
    endtask

    // Load a fresh subtree under node 0, then query it with random points
    task automatic grow_tree(input bit deep);
        logic [bsp_loc_pkg::INDEX_W-1:0] ids[$];
        logic [bsp_loc_pkg::INDEX_W-1:0] pl_ids[$];
        int unsigned                     depth;
        int unsigned                     cand;
        int unsigned                     steady;
        int                              pref;
        int                              front;
        int                              back;
        bit                              dup;
        steady = 0;
        repeat ($urandom_range(1, 4))
        begin
            cand = $urandom_range(0, PLANE_COUNT - 1);
            send_plane(cand, rand_normal(), rand_normal(), rand_normal(), rand_distance());
            pl_ids.push_back(bsp_loc_pkg::INDEX_W'(cand));
        end
        if (deep)
        begin
            // zero normal and a distance at or below zero always send the point front
            steady = $urandom_range(0, PLANE_COUNT - 1);
            send_plane(steady, 0, 0, 0, -int'($urandom_range(0, 8388608)));
        end
        depth = deep ? $urandom_range(20, 60) : $urandom_range(1, 12);
        ids.push_back('0);
        while (ids.size() < depth)
        begin
            cand = $urandom_range(1, NODE_COUNT - 1);
            dup  = 1'b0;
            foreach (ids[j])
                if (ids[j] == cand)
                    dup = 1'b1;
            if (!dup)
                ids.push_back(bsp_loc_pkg::INDEX_W'(cand));
        end
        // Load children before parents, root last
        for (int k = depth - 1; k >= 0; k--)
        begin
            if (deep)
            begin
                pref = ($urandom_range(0, 15) != 0)
                     ? int'(steady)
                     : int'(pl_ids[$urandom_range(0, pl_ids.size() - 1)]);
                if (k + 1 < depth)
                    front = int'(ids[k + 1]);
                else
                    front = ($urandom_range(0, 2) == 0) ? 0 : rand_leaf();
                back = rand_leaf();
            end
            else
            begin
                if ($urandom_range(0, 2) != 0)
                    pref = int'(pl_ids[$urandom_range(0, pl_ids.size() - 1)]);
                else
                    pref = int'(live_planes[$urandom_range(0, live_planes.size() - 1)]);
                front = pick_child(ids, k);
                back  = pick_child(ids, k);
            end
            send_node(int'(ids[k]), pref, front, back);
        end
        repeat ($urandom_range(1, 8))
            send_locate(rand_coord(), rand_coord(), rand_coord());
    endtask

    // Mix in unused commands, dropped node loads and stray table loads
    task automatic add_noise();
        logic [bsp_loc_pkg::INDEX_W-1:0] self_q[$];
        int unsigned                     idx;
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 3))
                0: send_item(blank_item(bsp_loc_pkg::CMD_UNUSED));
                1: send_node($urandom_range(NODE_COUNT, 8191), $urandom_range(0, 8191),
                             int'($urandom_range(0, 12287)) - 8192,
                             int'($urandom_range(0, 12287)) - 8192);
                2: send_plane($urandom_range(0, PLANE_COUNT - 1), rand_normal(), rand_normal(),
                              rand_normal(), rand_distance());
                default:
                begin
                    idx = $urandom_range(0, NODE_COUNT - 1);
                    self_q.delete();
                    self_q.push_back(bsp_loc_pkg::INDEX_W'(idx));
                    send_node(idx,
                              int'(live_planes[$urandom_range(0, live_planes.size() - 1)]),
                              pick_child(self_q, 0), pick_child(self_q, 0));
                end
            endcase
        end
    endtask

    initial
    begin
        int unsigned scene;
        int unsigned pick;
        board          = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = bsp_loc_pkg::CMD_UNUSED;
        entry_index    = '0;
        plane_ref      = '0;
        front_child    = '0;
        back_child     = '0;
        normal_x       = '0;
        normal_y       = '0;
        normal_z       = '0;
        plane_distance = '0;
        point_x        = '0;
        point_y        = '0;
        point_z        = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, ties, dropped loads, unused command, step cap
        send_plane(0, 16384, -16384, -16384, -8388608);
        send_plane(PLANE_COUNT - 1, -16384, 16384, 16384, 8388607);
        send_plane(1, 0, 0, 0, 0);
        send_node(0, 0, -1, -LEAF_COUNT);
        send_locate(8388607, 8388607, 8388607);
        send_locate(-8388608, 8388607, 8388607);
        send_node(NODE_COUNT - 1, PLANE_COUNT - 1, -4096, NODE_COUNT - 1);
        send_node(0, 1, NODE_COUNT - 1, -1);
        send_locate(0, 0, 0);
        send_locate(-8388608, 8388607, 8388607);
        send_node(NODE_COUNT, 1, -100, -100);
        send_node(8191, 1, -200, -200);
        send_item(blank_item(bsp_loc_pkg::CMD_UNUSED));
        send_locate(-8388608, 8388607, 8388607);
        send_plane(1, 0, 0, 0, 1);
        send_locate(0, 0, 0);

        // Random trees, deep chains and noise
        scene = 0;
        while (work_sent < ITEM_GOAL)
        begin
            scene++;
            idle_on = (work_sent + CALM_ITEMS < ITEM_GOAL) && ($urandom_range(0, 3) != 0);
            if (scene == 12)
                long_hold_req = 1'b1;
            if (scene == 25)
            begin
                // Pause the sender until every result is back
                in_valid <= 1'b0;
                @(posedge clk);
                while (board.pending() != 0) @(posedge clk);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0 && scene != 12)
                add_noise();
            else
                grow_tree(pick == 1);
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Drain, then give a stray item time to show up
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending() != 0)
            board.report($sformatf("%0d results never arrived", board.pending()));
        if (board.fail_count == 0)
            $display("bsp_point_leaf_locator regression: pass");
        else
            $display("bsp_point_leaf_locator regression: fail");
        $finish;
    end

endmodule
